FILE: rtl/lc_pkg.sv
// ----------------------------------------------------------------------------
// lc_pkg
// Shared constants, types and the elaboration-time sigmoid table builder for
// the logistic classifier.
// ----------------------------------------------------------------------------
package lc_pkg;

  localparam int unsigned LC_TABLE_POINTS = 64;
  localparam int unsigned LC_TABLE_MAX    = 1024;
  localparam int unsigned LC_QDEPTH       = 4;

  localparam int unsigned LC_FEAT_W  = 16;
  localparam int unsigned LC_PROD_W  = 32;
  localparam int unsigned LC_ACC_W   = 48;
  localparam int unsigned LC_LIM_W   = 17;
  localparam int unsigned LC_LOGIT_W = 18;
  localparam int unsigned LC_PROB_W  = 16;

  // Logit span of the table in Q5.12 (20.0) and its factorization 5 * 2^14.
  localparam logic [16:0] LC_LOGIT_SPAN = 17'd81920;
  localparam logic [16:0] LC_HALF_SPAN  = 17'd40960;
  localparam int unsigned LC_SPAN_SHIFT = 14;
  // ceil(2^24 / 5): exact floor(x / 5) for every x below 2^22.
  localparam logic [21:0] LC_RECIP5     = 22'd3355444;
  localparam int unsigned LC_RECIP5_SH  = 24;

  typedef logic [15:0] sig_tab_t [0:LC_TABLE_MAX];

  typedef enum logic [2:0] {
    LC_IDLE,
    LC_POS,
    LC_DIV,
    LC_LOOK,
    LC_MUL,
    LC_ROUND,
    LC_FINISH
  } lc_state_t;

  // Restoring long division, used only while building constants.
  function automatic logic [63:0] lc_udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Samples of 65536 / (1 + exp(-20 i / points)) in Q0.16, capped at 65535.
  // The exponential is built in Q2.30 from a Taylor series of exp(h), its
  // rounded reciprocal and repeated rounded multiplication.
  function automatic sig_tab_t lc_build_table(input int unsigned points);
    sig_tab_t    tab;
    logic [63:0] one;
    logic [63:0] h;
    logic [63:0] eh;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] v;
    one  = 64'd1 << 30;
    h    = lc_udiv64(64'd20 << 30, 64'(points));
    eh   = one;
    term = one;
    for (int k = 1; k <= 24; k++) begin
      term = lc_udiv64((term * h) >> 30, 64'(k));
      eh   = eh + term;
    end
    r = lc_udiv64((64'd1 << 60) + (eh >> 1), eh);
    p = one;
    for (int i = 0; i <= int'(LC_TABLE_MAX); i++) begin
      if (i <= int'(points)) begin
        d      = one + p;
        v      = lc_udiv64((64'd1 << 46) + (d >> 1), d);
        tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        p      = (p * r + (64'd1 << 29)) >> 30;
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

endpackage

FILE: rtl/logistic_classifier.sv
// ----------------------------------------------------------------------------
// logistic_classifier
// Streaming logistic-regression inference with a table-based sigmoid.
// ----------------------------------------------------------------------------
// The block takes one feature/weight pair (signed Q4.12) per clock and adds
// the exact product into a saturating 48-bit accumulator; the pair marked as
// last closes the vector and yields one result: the logit rounded to Q5.12
// and clamped to plus or minus cfg_wr_data's bound, and its sigmoid in
// unsigned Q0.16. While full is low, the multiply-accumulate front sustains
// one pair per cycle. A result passes the product and final-sum registers
// into a four-entry queue; the sigmoid sequencer steps it through position,
// divide, lookup, multiply, round and finish states and holds it till popped.
// full rises only when the queue, counting results still in the front, would
// overflow; vectors of seven or more pairs stream unstalled as pop keeps up.
module logistic_classifier
  import lc_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = LC_TABLE_POINTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [LC_LIM_W-1:0]          cfg_wr_data,
  input  logic                         push,
  output logic                         full,
  input  logic signed [LC_FEAT_W-1:0]  in_feature,
  input  logic signed [LC_FEAT_W-1:0]  in_weight,
  input  logic                         in_last_element,
  output logic                         empty,
  input  logic                         pop,
  output logic [LC_PROB_W-1:0]         out_probability,
  output logic signed [LC_LOGIT_W-1:0] out_logit
);

  logic [LC_LIM_W-1:0]            clamp_limit_r;
  logic                           q_push;
  logic signed [LC_LOGIT_W-1:0]   q_wr_logit;
  logic                           q_pop;
  logic [LC_LOGIT_W-1:0]          q_rd_logit;
  logic                           q_empty;
  logic [$clog2(LC_QDEPTH+1)-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_limit_r <= LC_LOGIT_SPAN;
    end else if (cfg_wr_en) begin
      clamp_limit_r <= cfg_wr_data;
    end
  end

  lc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_feature      (in_feature),
    .in_weight       (in_weight),
    .in_last_element (in_last_element),
    .clamp_limit     (clamp_limit_r),
    .q_count         (q_count),
    .q_push          (q_push),
    .q_logit         (q_wr_logit)
  );

  lc_fifo #(
    .WIDTH (LC_LOGIT_W),
    .DEPTH (LC_QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_logit),
    .rd_en   (q_pop),
    .rd_data (q_rd_logit),
    .empty   (q_empty),
    .count   (q_count)
  );

  lc_back #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_logit         (q_rd_logit),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_probability (out_probability),
    .out_logit       (out_logit)
  );

endmodule

FILE: rtl/lc_fifo.sv
// ----------------------------------------------------------------------------
// lc_fifo
// Small register queue carrying finished logits from the front to the back.
// ----------------------------------------------------------------------------
module lc_fifo
  import lc_pkg::*;
#(
  parameter int unsigned WIDTH = LC_LOGIT_W,
  parameter int unsigned DEPTH = LC_QDEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule

FILE: rtl/lc_front.sv
// ----------------------------------------------------------------------------
// lc_front
// Multiply-accumulate front end: one feature/weight request per cycle while
// full is low, a saturating 48-bit sum, and rounding and clamping of the
// logit at the end of each vector.
// ----------------------------------------------------------------------------
module lc_front
  import lc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [LC_FEAT_W-1:0]   in_feature,
  input  logic signed [LC_FEAT_W-1:0]   in_weight,
  input  logic                          in_last_element,
  input  logic [LC_LIM_W-1:0]           clamp_limit,
  input  logic [$clog2(LC_QDEPTH+1)-1:0] q_count,
  output logic                          q_push,
  output logic signed [LC_LOGIT_W-1:0]  q_logit
);

  localparam int unsigned CW = $clog2(LC_QDEPTH+1) + 1;
  localparam int unsigned QW = LC_ACC_W + 1 - 12;

  logic                         accept;
  logic signed [LC_PROD_W-1:0]  prod_r;
  logic                         s1_vld_r;
  logic                         s1_last_r;
  logic signed [LC_ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [LC_ACC_W-1:0]   fin_r;
  logic                         fin_vld_r;
  logic signed [LC_ACC_W:0]     sum;
  logic signed [LC_ACC_W-1:0]   sum_sat;
  logic signed [LC_ACC_W:0]     rnd;
  logic signed [QW-1:0]         q_raw;
  logic signed [QW-1:0]         lim_pos;
  logic signed [QW-1:0]         lim_neg;
  logic signed [QW-1:0]         q_clamp;
  logic [CW-1:0]                pending;

  assign accept = push && !full;

  // Results already on their way to the queue count against its room, so
  // the queue never has to refuse a push.
  assign pending = CW'(q_count) + CW'(s1_vld_r && s1_last_r) + CW'(fin_vld_r);
  assign full    = (pending >= CW'(LC_QDEPTH));

  always_comb begin
    sum = {acc_r[LC_ACC_W-1], acc_r} + (LC_ACC_W+1)'(prod_r);
    if (sum[LC_ACC_W] != sum[LC_ACC_W-1]) begin
      sum_sat = sum[LC_ACC_W] ? {1'b1, {(LC_ACC_W-1){1'b0}}} : {1'b0, {(LC_ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[LC_ACC_W-1:0];
    end
    acc_nxt = acc_r;
    if (s1_vld_r) begin
      acc_nxt = s1_last_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      fin_vld_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      s1_vld_r  <= accept;
      s1_last_r <= accept && in_last_element;
      fin_vld_r <= s1_vld_r && s1_last_r;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= in_feature * in_weight;
    end
    if (s1_vld_r && s1_last_r) begin
      fin_r <= sum_sat;
    end
  end

  // Round half up to Q5.12 by flooring after adding half an LSB.
  always_comb begin
    rnd     = {fin_r[LC_ACC_W-1], fin_r} + (LC_ACC_W+1)'(2048);
    q_raw   = rnd[LC_ACC_W:12];
    lim_pos = QW'(clamp_limit);
    lim_neg = -lim_pos;
    if (q_raw > lim_pos) begin
      q_clamp = lim_pos;
    end else if (q_raw < lim_neg) begin
      q_clamp = lim_neg;
    end else begin
      q_clamp = q_raw;
    end
  end

  assign q_push  = fin_vld_r;
  assign q_logit = q_clamp[LC_LOGIT_W-1:0];

endmodule

FILE: rtl/lc_back.sv
// ----------------------------------------------------------------------------
// lc_back
// Sigmoid sequencer: takes one logit from the queue, interpolates the table
// over several steps and holds the result in the output register.
// ----------------------------------------------------------------------------
module lc_back
  import lc_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = LC_TABLE_POINTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic signed [LC_LOGIT_W-1:0] q_logit,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [LC_PROB_W-1:0]         out_probability,
  output logic signed [LC_LOGIT_W-1:0] out_logit
);

  localparam int unsigned IDX_W = $clog2(TABLE_POINTS+1);
  localparam int unsigned POS_W = LC_LIM_W + IDX_W;
  localparam int unsigned X_W   = POS_W - LC_SPAN_SHIFT;
  localparam int unsigned XP_W  = X_W + 22;
  localparam int unsigned D_W   = LC_PROB_W + LC_LIM_W;
  localparam int unsigned V_W   = D_W + 1;
  localparam int unsigned Y_W   = V_W - LC_SPAN_SHIFT;
  localparam int unsigned YP_W  = Y_W + 22;

  localparam sig_tab_t SIG_FULL = lc_build_table(TABLE_POINTS);

  logic [LC_PROB_W-1:0] sig_tab [TABLE_POINTS+1];

  for (genvar g = 0; g <= int'(TABLE_POINTS); g++) begin : g_tab
    assign sig_tab[g] = SIG_FULL[g];
  end

  lc_state_t state_r, state_nxt;

  logic signed [LC_LOGIT_W-1:0] lg_r;
  logic                         neg_r;
  logic [POS_W-1:0]             pos_r;
  logic [IDX_W-1:0]             idx_r;
  logic [LC_LIM_W-1:0]          frac_r;
  logic [LC_PROB_W-1:0]         lo_r;
  logic [LC_PROB_W-1:0]         diff_r;
  logic [D_W-1:0]               prod_r;
  logic [LC_LIM_W-1:0]          qy_r;
  logic                         out_vld_r;
  logic [LC_PROB_W-1:0]         prob_r;
  logic signed [LC_LOGIT_W-1:0] logit_r;
  logic                         out_load;

  logic [LC_LIM_W-1:0]  mag;
  logic [LC_LIM_W-1:0]  mag_sat;
  logic [X_W-1:0]       pos_x;
  logic [XP_W-1:0]      pos_xp;
  logic [X_W-1:0]       rem_x;
  logic [LC_PROB_W-1:0] t_lo;
  logic [LC_PROB_W-1:0] t_hi;
  logic [V_W-1:0]       rnd_v;
  logic [YP_W-1:0]      rnd_yp;
  logic [LC_LIM_W:0]    y_sum;
  logic [LC_LIM_W:0]    y_fin;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LC_IDLE:   if (!q_empty) state_nxt = LC_POS;
      LC_POS:    state_nxt = LC_DIV;
      LC_DIV:    state_nxt = LC_LOOK;
      LC_LOOK:   state_nxt = LC_MUL;
      LC_MUL:    state_nxt = LC_ROUND;
      LC_ROUND:  state_nxt = LC_FINISH;
      LC_FINISH: if (!out_vld_r || pop) state_nxt = LC_IDLE;
      default:   state_nxt = LC_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      LC_IDLE:   q_pop = !q_empty;
      LC_FINISH: out_load = !out_vld_r || pop;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= LC_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // The magnitude fits 17 bits since the clamp keeps the logit above -2^17.
  always_comb begin
    mag     = lg_r[LC_LOGIT_W-1] ? LC_LIM_W'(-lg_r) : LC_LIM_W'(lg_r);
    mag_sat = (mag > LC_LOGIT_SPAN) ? LC_LOGIT_SPAN : mag;
    // Division by 81920 splits into a shift by 14 and a divide by 5.
    pos_x   = pos_r[POS_W-1:LC_SPAN_SHIFT];
    pos_xp  = XP_W'(pos_x) * XP_W'(LC_RECIP5);
    rem_x   = pos_x - ((X_W'(idx_r) << 2) + X_W'(idx_r));
    if (idx_r >= IDX_W'(TABLE_POINTS)) begin
      t_lo = sig_tab[IDX_W'(TABLE_POINTS)];
      t_hi = t_lo;
    end else begin
      t_lo = sig_tab[idx_r];
      t_hi = sig_tab[idx_r + IDX_W'(1)];
    end
    rnd_v  = V_W'(prod_r) + V_W'(LC_HALF_SPAN);
    rnd_yp = YP_W'(rnd_v[V_W-1:LC_SPAN_SHIFT]) * YP_W'(LC_RECIP5);
    y_sum  = (LC_LIM_W+1)'(lo_r) + (LC_LIM_W+1)'(qy_r);
    y_fin  = neg_r ? ((LC_LIM_W+1)'(65536) - y_sum) : y_sum;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      LC_IDLE: begin
        lg_r <= q_logit;
      end
      LC_POS: begin
        neg_r <= lg_r[LC_LOGIT_W-1];
        pos_r <= POS_W'(mag_sat) * POS_W'(TABLE_POINTS);
      end
      LC_DIV: begin
        idx_r <= pos_xp[LC_RECIP5_SH +: IDX_W];
      end
      LC_LOOK: begin
        frac_r <= {rem_x[2:0], pos_r[LC_SPAN_SHIFT-1:0]};
        lo_r   <= t_lo;
        diff_r <= (t_hi > t_lo) ? (t_hi - t_lo) : '0;
      end
      LC_MUL: begin
        prod_r <= D_W'(diff_r) * D_W'(frac_r);
      end
      LC_ROUND: begin
        qy_r <= rnd_yp[LC_RECIP5_SH +: LC_LIM_W];
      end
      default: begin
        qy_r <= qy_r;
      end
    endcase
    if (out_load) begin
      prob_r  <= (y_fin > (LC_LIM_W+1)'(65535)) ? 16'hFFFF : y_fin[LC_PROB_W-1:0];
      logit_r <= lg_r;
    end
  end

  assign empty           = !out_vld_r;
  assign out_probability = prob_r;
  assign out_logit       = logit_r;

endmodule
